// ===== sv/bbm_pkg.sv =====
// Shared constants for the bounding box merge block.
`default_nettype none
package bbm_pkg;
    localparam int MAX_BOXES_DEF  = 64;
    localparam int COORD_BITS_DEF = 12;
endpackage
`default_nettype wire

// ===== sv/bbm_box_ram.sv =====
// Box table memory: one write port, one read port with registered read data.
`default_nettype none
module bbm_box_ram #(
    parameter int DEPTH = bbm_pkg::MAX_BOXES_DEF,
    parameter int WIDTH = 4 * bbm_pkg::COORD_BITS_DEF + 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    import bbm_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== sv/bbm_fold.sv =====
// Touch test against the original box and union of a candidate into the accumulated box.
`default_nettype none
module bbm_fold #(
    parameter int COORD_BITS = bbm_pkg::COORD_BITS_DEF
) (
    input  wire logic                      i_mode,
    input  wire logic [4*COORD_BITS+1:0]   i_orig,
    input  wire logic [4*COORD_BITS+1:0]   i_acc,
    input  wire logic [4*COORD_BITS+1:0]   i_cand,
    output logic                           o_touch,
    output logic      [4*COORD_BITS+1:0]   o_union
);
    import bbm_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int EB = CB + 2;
    localparam logic [EB-1:0] SIZE_MAX = {1'b0, {(CB + 1){1'b1}}};

    // Entries are packed as {x, y, width, height}.
    function automatic logic [EB-1:0] f_pos(input logic [4*CB+1:0] e, input logic ax);
        f_pos = ax ? {2'b00, e[4*CB+1 -: CB]} : {2'b00, e[3*CB+1 -: CB]};
    endfunction

    function automatic logic [EB-1:0] f_size(input logic [4*CB+1:0] e, input logic ax);
        f_size = ax ? {1'b0, e[2*CB+1 -: CB+1]} : {1'b0, e[CB:0]};
    endfunction

    logic [EB-1:0] ox, oy, bx, by, oxe, oye, bxe, bye;
    logic [EB-1:0] ax_p, ay_p, axe, aye;
    logic [EB-1:0] lo_x, lo_y, hi_x, hi_y, sz_x, sz_y;
    logic          ok_y, ok_x;

    always_comb begin
        ox  = f_pos(i_orig, 1'b1);
        oy  = f_pos(i_orig, 1'b0);
        bx  = f_pos(i_cand, 1'b1);
        by  = f_pos(i_cand, 1'b0);
        oxe = ox + f_size(i_orig, 1'b1);
        oye = oy + f_size(i_orig, 1'b0);
        bxe = bx + f_size(i_cand, 1'b1);
        bye = by + f_size(i_cand, 1'b0);
        ok_y = (oy <= bye) && (by <= oye);
        ok_x = (ox <= bxe) && (bx <= oxe);
        o_touch = ok_y && (i_mode || ok_x);

        ax_p = f_pos(i_acc, 1'b1);
        ay_p = f_pos(i_acc, 1'b0);
        axe  = ax_p + f_size(i_acc, 1'b1);
        aye  = ay_p + f_size(i_acc, 1'b0);
        lo_x = (ax_p < bx) ? ax_p : bx;
        lo_y = (ay_p < by) ? ay_p : by;
        hi_x = (axe > bxe) ? axe : bxe;
        hi_y = (aye > bye) ? aye : bye;
        sz_x = hi_x - lo_x;
        sz_y = hi_y - lo_y;
        if (sz_x > SIZE_MAX) begin
            sz_x = SIZE_MAX;
        end
        if (sz_y > SIZE_MAX) begin
            sz_y = SIZE_MAX;
        end
        o_union = {lo_x[CB-1:0], lo_y[CB-1:0], sz_x[CB:0], sz_y[CB:0]};
    end
endmodule
`default_nettype wire

// ===== sv/bounding_box_merge_top.sv =====
// Top level of the bounding box merge block: load, merge sequencer and emission.
// Boxes load at one item per cycle while o_in_stall is low; a last item starts the merge, which
// reads and tests each later box of the inner scan (S_RDJ, S_CMPJ) for every outer position, and the
// scan never goes back below a merged position.
// Emission reads each surviving box through the single table read port (S_ERD), then moves it out (S_ELD).
// Reset is synchronous and active low; it empties the list and clears the mode register.
`default_nettype none
module bounding_box_merge_top #(
    parameter int MAX_BOXES  = bbm_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = bbm_pkg::COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [COORD_BITS-1:0] i_box_x,
    input  wire logic [COORD_BITS-1:0] i_box_y,
    input  wire logic [COORD_BITS:0]   i_box_width,
    input  wire logic [COORD_BITS:0]   i_box_height,
    input  wire logic                  i_last_box,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic      [COORD_BITS-1:0] o_out_x,
    output logic      [COORD_BITS-1:0] o_out_y,
    output logic      [COORD_BITS:0]   o_out_width,
    output logic      [COORD_BITS:0]   o_out_height,
    output logic                       o_out_last,
    output logic                       o_dropped
);
    import bbm_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int EW = 4 * CB + 2;
    localparam int AW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam logic [CW-1:0] CAP = CW'(MAX_BOXES);
    localparam logic [CW-1:0] ONE = CW'(1);

    // One-hot sequencer states.
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,  // taking boxes
        S_RDI  = 8'b0000_0010,  // read the box at the scan position
        S_LDI  = 8'b0000_0100,  // capture it as the original rectangle
        S_RDJ  = 8'b0000_1000,  // read a later box
        S_CMPJ = 8'b0001_0000,  // test, fold or compact it
        S_WRI  = 8'b0010_0000,  // write back the union at the end of a pass
        S_ERD  = 8'b0100_0000,  // read a surviving box
        S_ELD  = 8'b1000_0000   // move it into the output register
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_cnt, r_i, r_j, r_k, r_e;
    logic          r_ovf, r_mode, r_mode_act, r_hit;
    logic [EW-1:0] r_orig, r_acc;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata, fold_union;
    logic          fold_touch, in_acc, out_free;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !o_out_valid || !i_out_stall;

    bbm_box_ram #(.DEPTH(MAX_BOXES), .WIDTH(EW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    bbm_fold #(.COORD_BITS(CB)) u_fold (
        .i_mode (r_mode_act),
        .i_orig (r_orig),
        .i_acc  (r_acc),
        .i_cand (ram_rdata),
        .o_touch(fold_touch),
        .o_union(fold_union)
    );

    // Table port selection. Compaction writes go to a slot at or below the box just read,
    // and every read is issued in a later cycle than any write it could depend on.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cnt[AW-1:0];
        ram_wdata = {i_box_x, i_box_y, i_box_width, i_box_height};
        ram_re    = 1'b0;
        ram_raddr = r_i[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                ram_we = in_acc && (r_cnt < CAP);
            end
            S_RDI: begin
                ram_re = 1'b1;
            end
            S_RDJ: begin
                ram_re    = 1'b1;
                ram_raddr = r_j[AW-1:0];
            end
            S_CMPJ: begin
                ram_we    = !fold_touch;
                ram_waddr = r_k[AW-1:0];
                ram_wdata = ram_rdata;
            end
            S_WRI: begin
                ram_we    = r_hit;
                ram_waddr = r_i[AW-1:0];
                ram_wdata = r_acc;
            end
            S_ERD: begin
                ram_re    = 1'b1;
                ram_raddr = r_e[AW-1:0];
            end
            S_LDI, S_ELD: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_e         <= '0;
            r_ovf       <= 1'b0;
            r_mode      <= 1'b0;
            r_mode_act  <= 1'b0;
            r_hit       <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            // In S_ELD the output register is reloaded below whenever it is taken.
            if (o_out_valid && !i_out_stall && (r_state != S_ELD)) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (r_cnt < CAP) begin
                            r_cnt <= r_cnt + ONE;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last_box) begin
                            r_mode_act <= r_mode;
                            r_i        <= '0;
                            r_state    <= S_RDI;
                        end
                    end
                end
                S_RDI: begin
                    // Nothing left to pair with: the list is final.
                    if (r_i + ONE >= r_cnt) begin
                        r_e     <= '0;
                        r_state <= S_ERD;
                    end else begin
                        r_state <= S_LDI;
                    end
                end
                S_LDI: begin
                    r_orig  <= ram_rdata;
                    r_acc   <= ram_rdata;
                    r_j     <= r_i + ONE;
                    r_k     <= r_i + ONE;
                    r_hit   <= 1'b0;
                    r_state <= S_RDJ;
                end
                S_RDJ: begin
                    r_state <= S_CMPJ;
                end
                S_CMPJ: begin
                    if (fold_touch) begin
                        r_acc <= fold_union;
                        r_hit <= 1'b1;
                    end else begin
                        r_k <= r_k + ONE;
                    end
                    r_j     <= r_j + ONE;
                    r_state <= (r_j + ONE == r_cnt) ? S_WRI : S_RDJ;
                end
                S_WRI: begin
                    // After a merge the scan resumes at the same position.
                    if (r_hit) begin
                        r_cnt <= r_k;
                    end else begin
                        r_i <= r_i + ONE;
                    end
                    r_state <= S_RDI;
                end
                S_ERD: begin
                    r_state <= S_ELD;
                end
                S_ELD: begin
                    if (out_free) begin
                        o_out_valid <= 1'b1;
                        if (r_e + ONE == r_cnt) begin
                            r_cnt   <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_ERD;
                        end
                        r_e <= r_e + ONE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (r_state == S_ELD && out_free) begin
            o_out_x      <= ram_rdata[4*CB+1 -: CB];
            o_out_y      <= ram_rdata[3*CB+1 -: CB];
            o_out_width  <= ram_rdata[2*CB+1 -: CB+1];
            o_out_height <= ram_rdata[CB:0];
            o_out_last   <= (r_e + ONE == r_cnt);
            o_dropped    <= r_ovf;
        end
    end

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CAP) else $error("box count above capacity");

    a_compact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMPJ) |-> (r_k <= r_j && r_j < r_cnt))
        else $error("compaction slot or scan index out of order");

    a_wri_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRI) |=> (r_state == S_RDI))
        else $error("pass end did not restart the scan");

    a_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRI && r_hit) |=> (r_cnt < $past(r_cnt)))
        else $error("merge did not shrink the list");
endmodule
`default_nettype wire
